// ===== design/unf_pkg.sv =====
// Shared types, template table and constants for the unpredictable encoding filter.
`timescale 1ns / 1ps

package unf_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned REG_W      = 5;
   localparam int unsigned TMPL_COUNT = 13;

   // register index that names SP/ZR in the base field
   localparam logic [REG_W-1:0] REG_SP = 5'd31;

   // register condition checked once the fixed bits agree
   typedef enum logic [2:0] {
      RULE_T_N,
      RULE_TT2_N,
      RULE_TT2_N_OR,
      RULE_T_T2,
      RULE_SIMD_PAIR
   } rule_type;

   typedef struct packed {
      logic [WORD_W-1:0] fixed_mask;
      logic [WORD_W-1:0] pattern;
      rule_type          rule;
   } tmpl_type;

   localparam tmpl_type TMPL_TABLE [TMPL_COUNT] = '{
      '{32'h3FA0_0000, 32'h3800_0000, RULE_T_N},        // load register, writeback
      '{32'h7EC0_0000, 32'h28C0_0000, RULE_TT2_N_OR},   // load pair, writeback
      '{32'h7FC0_0000, 32'h2940_0000, RULE_T_T2},       // load pair, signed offset
      '{32'h3FE0_0000, 32'h38C0_0000, RULE_T_N},        // load signed register
      '{32'h7EC0_0000, 32'h2880_0000, RULE_TT2_N},      // store pair, writeback
      '{32'hFEC0_0000, 32'h68C0_0000, RULE_TT2_N_OR},   // load pair signed word, wb
      '{32'hFFC0_0000, 32'h6940_0000, RULE_T_T2},       // load pair signed word, offset
      '{32'h7FC0_0000, 32'h2840_0000, RULE_T_T2},       // load non-temporal pair
      '{32'hBFC0_0000, 32'h2C40_0000, RULE_T_T2},       // SIMD non-temporal pair 32/64
      '{32'hFFC0_0000, 32'hAC40_0000, RULE_T_T2},       // SIMD non-temporal pair 128
      '{32'h3E40_0000, 32'h2C40_0000, RULE_SIMD_PAIR},  // SIMD load pair
      '{32'hBFE0_8000, 32'h8860_8000, RULE_T_T2},       // load-acquire exclusive pair
      '{32'hBFE0_8000, 32'h8860_0000, RULE_T_T2}        // load exclusive pair
   };

endpackage

// ===== design/unf_match.sv =====
// Template matcher: flags a word that hits any unpredictable encoding template.
`timescale 1ns / 1ps

module unf_match
   import unf_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   output logic              drop
);

   logic [REG_W-1:0] fld_t;
   logic [REG_W-1:0] fld_n;
   logic [REG_W-1:0] fld_t2;
   logic [1:0]       fld_idx;
   logic [1:0]       fld_opc;
   logic             wb_single;
   logic             wb_pair;
   logic             same;
   logic             simd_ok;
   logic [TMPL_COUNT-1:0] hit;

   // register fields
   assign fld_t   = word[4:0];
   assign fld_n   = word[9:5];
   assign fld_t2  = word[14:10];
   assign fld_idx = word[24:23];
   assign fld_opc = word[31:30];

   // shared register conditions
   assign wb_single = (fld_t == fld_n) && (fld_n != REG_SP);
   assign wb_pair   = ((fld_t == fld_n) || (fld_t2 == fld_n)) && (fld_n != REG_SP);
   assign same      = (fld_t == fld_t2);
   assign simd_ok   = (fld_idx != 2'd0) && (fld_opc != 2'd3) && same;

   // one compare per template, independent of each other
   always_comb begin
      for (int i = 0; i < TMPL_COUNT; i++) begin
         hit[i] = 1'b0;
         if ((word & TMPL_TABLE[i].fixed_mask) == TMPL_TABLE[i].pattern) begin
            unique case (TMPL_TABLE[i].rule)
               RULE_T_N:       hit[i] = wb_single;
               RULE_TT2_N:     hit[i] = wb_pair;
               RULE_TT2_N_OR:  hit[i] = wb_pair || same;
               RULE_T_T2:      hit[i] = same;
               RULE_SIMD_PAIR: hit[i] = simd_ok;
               default:        hit[i] = 1'b0;
            endcase
         end
      end
   end

   assign drop = |hit;

endmodule

// ===== design/unpredictable_encoding_filter_core.sv =====
// Top level: input register, template match, result register with stall handling.
// A kept word passes from the input register into the result register, which drives rsp_.
// Throughput: one word per cycle unless the result is stalled; the match sits between the input and result registers.
// A stalled result still lets the input stage take a word while it is empty or dropping.
// Reset (synchronous, active high) clears both valid flags; data registers are not reset.
`timescale 1ns / 1ps

module unpredictable_encoding_filter_core
   import unf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_instruction_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_kept_word
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [WORD_W-1:0] out_word_ff;
   logic              in_drop;
   logic              out_free;
   logic              in_move;

   unf_match u_match (
      .word (in_word_ff),
      .drop (in_drop)
   );

   // handshake: input stage moves if empty, dropping, or the result slot frees
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = !in_valid_ff || in_drop || out_free;
   assign req_stall = !in_move;

   assign in_valid_in  = in_move ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? (in_valid_ff && !in_drop) : out_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (in_move) begin
         in_word_ff <= req_instruction_word;
      end
      if (out_free) begin
         out_word_ff <= in_word_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kept_word = out_word_ff;

`ifndef SYNTHESIS
   // a kept word moves into a free result slot unchanged
   a_kept_forward: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_drop && out_free |=> out_valid_ff && out_word_ff == $past(in_word_ff))
      else $error("kept word did not reach result register");

   // a dropped word never turns into a result
   a_drop_gone: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_drop && !out_valid_ff |=> !out_valid_ff)
      else $error("dropped word produced a result");

   // input stalls only when both stages are full and the output is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall && !in_drop)
      else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for the unpredictable encoding filter: directed table plus shaped random words.
`timescale 1ns / 1ps

module tb_top;
   import unf_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned RANDOM_WORDS = 600;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned ROW_COUNT    = 25;

   // how a directed row's outcome is known
   typedef enum logic [1:0] {
      OUT_KEPT,
      OUT_DROPPED,
      OUT_PREDICTED
   } outcome_type;

   typedef struct packed {
      logic [WORD_W-1:0] fixed_bits;
      logic [WORD_W-1:0] pattern;
      rule_type          cond;
   } filter_entry_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      outcome_type       outcome;
   } stim_row_type;

   // templates: fixed-bit mask, required pattern, register condition
   localparam filter_entry_type FILTER_TABLE [TMPL_COUNT] = '{
      '{32'h3FA0_0000, 32'h3800_0000, RULE_T_N},
      '{32'h7EC0_0000, 32'h28C0_0000, RULE_TT2_N_OR},
      '{32'h7FC0_0000, 32'h2940_0000, RULE_T_T2},
      '{32'h3FE0_0000, 32'h38C0_0000, RULE_T_N},
      '{32'h7EC0_0000, 32'h2880_0000, RULE_TT2_N},
      '{32'hFEC0_0000, 32'h68C0_0000, RULE_TT2_N_OR},
      '{32'hFFC0_0000, 32'h6940_0000, RULE_T_T2},
      '{32'h7FC0_0000, 32'h2840_0000, RULE_T_T2},
      '{32'hBFC0_0000, 32'h2C40_0000, RULE_T_T2},
      '{32'hFFC0_0000, 32'hAC40_0000, RULE_T_T2},
      '{32'h3E40_0000, 32'h2C40_0000, RULE_SIMD_PAIR},
      '{32'hBFE0_8000, 32'h8860_8000, RULE_T_T2},
      '{32'hBFE0_8000, 32'h8860_0000, RULE_T_T2}
   };

   // directed words: extremes, and template-shaped words with their condition met or missed
   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{32'h0000_0000, OUT_KEPT},
      '{32'hFFFF_FFFF, OUT_KEPT},
      '{32'h3800_0021, OUT_DROPPED},     // single register writeback, t == n
      '{32'h3800_03FF, OUT_PREDICTED},   // t == n but base is SP
      '{32'h38C0_00E7, OUT_PREDICTED},
      '{32'h28C0_0042, OUT_PREDICTED},   // pair load writeback, t == n
      '{32'h28C0_0C61, OUT_PREDICTED},   // t2 == n
      '{32'h28C0_13E4, OUT_PREDICTED},   // t == t2, base SP
      '{32'h28C0_03FF, OUT_PREDICTED},   // t == n == SP only
      '{32'h2940_1405, OUT_PREDICTED},
      '{32'h2940_1805, OUT_PREDICTED},
      '{32'h2880_2520, OUT_PREDICTED},   // pair store, t2 == n
      '{32'h2880_0C23, OUT_PREDICTED},   // pair store, t == t2 only
      '{32'h68C0_2BEA, OUT_PREDICTED},
      '{32'h6940_0000, OUT_PREDICTED},
      '{32'h2840_7C1F, OUT_PREDICTED},
      '{32'hAC40_08A2, OUT_PREDICTED},
      '{32'h2C40_0401, OUT_PREDICTED},   // SIMD pair, index 0
      '{32'h2CC0_0401, OUT_PREDICTED},   // SIMD pair, index 1
      '{32'h2DC0_0401, OUT_PREDICTED},   // SIMD pair, index 3
      '{32'hAD40_0401, OUT_PREDICTED},   // SIMD pair, opc 2
      '{32'hED40_0401, OUT_PREDICTED},   // SIMD pair, opc 3
      '{32'h8860_8C03, OUT_PREDICTED},
      '{32'h8860_0C03, OUT_PREDICTED},
      '{32'h8860_0C04, OUT_PREDICTED}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [WORD_W-1:0] req_instruction_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_kept_word;

   outcome_type       req_outcome = OUT_PREDICTED;
   logic [WORD_W-1:0] kept_words_due [$];
   logic [WORD_W-1:0] due_word;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;
   int unsigned       words_offered = 0;
   int unsigned       words_kept = 0;
   int unsigned       words_filtered = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       quiet_cycles = 0;

   unpredictable_encoding_filter_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kept_word        (rsp_kept_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // true when some template's fixed bits and register condition both hold
   function automatic bit word_is_unpredictable(input logic [WORD_W-1:0] w);
      logic [REG_W-1:0] rt, rn, rt2;
      bit wb_single, wb_pair, same, hit, cond_ok;
      rt        = w[4:0];
      rn        = w[9:5];
      rt2       = w[14:10];
      wb_single = (rt == rn) && (rn != REG_SP);
      wb_pair   = ((rt == rn) || (rt2 == rn)) && (rn != REG_SP);
      same      = (rt == rt2);
      hit       = 1'b0;
      for (int i = 0; i < TMPL_COUNT; i++) begin
         case (FILTER_TABLE[i].cond)
            RULE_T_N:       cond_ok = wb_single;
            RULE_TT2_N:     cond_ok = wb_pair;
            RULE_TT2_N_OR:  cond_ok = wb_pair || same;
            RULE_T_T2:      cond_ok = same;
            RULE_SIMD_PAIR: cond_ok = (w[24:23] != 2'd0) && (w[31:30] != 2'd3) && same;
            default:        cond_ok = 1'b0;
         endcase
         if ((w & FILTER_TABLE[i].fixed_bits) == FILTER_TABLE[i].pattern && cond_ok)
            hit = 1'b1;
      end
      return hit;
   endfunction

   task automatic note_mismatch(input string what, input logic [WORD_W-1:0] exp_word,
                                input logic [WORD_W-1:0] got_word);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_word, got_word);
   endtask

   // present one word and hold it until the transfer happens
   task automatic send_word(input logic [WORD_W-1:0] w, input outcome_type kind);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_instruction_word <= w;
      req_outcome          <= kind;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // check results, record expectations, track progress
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (kept_words_due.size() == 0) begin
               note_mismatch("word with nothing due", '0, rsp_kept_word);
            end else begin
               due_word = kept_words_due.pop_front();
               if (rsp_kept_word !== due_word)
                  note_mismatch("kept_word mismatch", due_word, rsp_kept_word);
            end
         end
         if (req_valid && !req_stall) begin
            words_offered++;
            if (req_outcome == OUT_KEPT ||
                (req_outcome == OUT_PREDICTED && !word_is_unpredictable(req_instruction_word))) begin
               kept_words_due = {kept_words_due, req_instruction_word};
               words_kept++;
            end else begin
               words_filtered++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // watchdog
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, kept_words_due.size());
      $display("simulation failed");
      $finish;
   end

   // stimulus
   initial begin
      logic [WORD_W-1:0] w;
      filter_entry_type  ent;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct  = 27;
      recv_stall_pct = 72;
      for (int r = 0; r < ROW_COUNT; r++)
         send_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].outcome);

      // idle mix per phase: sender-light, receiver-light, then none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 72 : 0;
         recv_stall_pct = (phase == 0) ? 72 : (phase == 1) ? 27 : 0;
         repeat (RANDOM_WORDS / 3) begin
            w = $urandom;
            // mostly template-shaped words with the register fields steered
            if ($urandom_range(0, 99) >= 20) begin
               ent = FILTER_TABLE[$urandom_range(0, TMPL_COUNT - 1)];
               w   = (w & ~ent.fixed_bits) | ent.pattern;
               case ($urandom_range(0, 4))
                  0: w[9:5]   = w[4:0];
                  1: w[9:5]   = w[14:10];
                  2: w[14:10] = w[4:0];
                  3: begin
                     w[9:5] = REG_SP;
                     w[4:0] = REG_SP;
                  end
                  default: ;
               endcase
            end
            send_word(w, OUT_PREDICTED);
         end
      end
      req_valid <= 1'b0;

      while (kept_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words sent (%0d directed): %0d passed through, %0d filtered out",
               words_offered, ROW_COUNT, words_kept, words_filtered);
      $display("idle mix 27/72, 72/27 and 0/0 percent for sender/receiver, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && kept_words_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
